### design/bhc_pkg.sv
// Shared constants, codes and beat types for the button hold classifier.
package bhc_pkg;

  // Number of low timestamp bits that take part in the hold-time arithmetic.
  localparam int unsigned TimeWidth = 64;
  localparam int unsigned ThrWidth  = 16;
  localparam int unsigned CfgIdxW   = 2;

  // Item kinds.
  localparam logic [1:0] FUNC_LEVEL = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_SOS   = 2'd2;

  // Event codes.
  localparam logic [2:0] EV_NONE          = 3'd0;
  localparam logic [2:0] EV_ADVANCE       = 3'd1;
  localparam logic [2:0] EV_HOLD_START    = 3'd2;
  localparam logic [2:0] EV_HOLD_CANCEL   = 3'd3;
  localparam logic [2:0] EV_SOS_ARM       = 3'd4;
  localparam logic [2:0] EV_RESET_PATH    = 3'd5;
  localparam logic [2:0] EV_SOS_DEDICATED = 3'd6;

  // LED override codes.
  localparam logic [1:0] LED_NONE    = 2'd0;
  localparam logic [1:0] LED_HOLD    = 2'd1;
  localparam logic [1:0] LED_SOS     = 2'd2;
  localparam logic [1:0] LED_RESTORE = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FEEDBACK = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SOS_HOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET    = 2'd2;

  // Reset values of the thresholds.
  localparam logic [ThrWidth-1:0] FEEDBACK_RST = 16'd500;
  localparam logic [ThrWidth-1:0] SOS_HOLD_RST = 16'd2000;
  localparam logic [ThrWidth-1:0] RESET_RST    = 16'd5000;

  typedef struct packed {
    logic [1:0]           func;
    logic                 pressed;
    logic [TimeWidth-1:0] now;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] led;
  } res_beat_t;

endpackage

### design/bhc_in_stage.sv
// Input register stage: captures one beat and holds it until the core takes it.
module bhc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bhc_pkg::in_beat_t  beat_i,
  input  logic               take_i,
  output logic               valid_o,
  output bhc_pkg::in_beat_t  beat_o
);

  logic              valid_q, valid_d;
  bhc_pkg::in_beat_t beat_q;
  logic              load;

  // The register can refill in the same cycle the core drains it.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### design/bhc_core.sv
// Classification logic with the press state and the threshold registers.
module bhc_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bhc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bhc_pkg::ThrWidth-1:0]      cfg_data_i,
  input  logic                              fire_i,
  input  bhc_pkg::in_beat_t                 beat_i,
  output bhc_pkg::res_beat_t                res_o
);

  localparam int unsigned TW = bhc_pkg::TimeWidth;

  logic [bhc_pkg::ThrWidth-1:0] fb_thr_q, sos_thr_q, rst_thr_q;

  logic          is_down_q, is_down_d;
  logic [TW-1:0] start_q, start_d;
  logic          fb_q, fb_d;
  logic          sos_q, sos_d;
  logic          rflag_q, rflag_d;

  logic [TW:0]   diff;
  logic          before_start;
  logic          ge_fb, ge_sos, ge_rst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_thr_q  <= bhc_pkg::FEEDBACK_RST;
      sos_thr_q <= bhc_pkg::SOS_HOLD_RST;
      rst_thr_q <= bhc_pkg::RESET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bhc_pkg::REG_FEEDBACK: fb_thr_q  <= cfg_data_i;
        bhc_pkg::REG_SOS_HOLD: sos_thr_q <= cfg_data_i;
        bhc_pkg::REG_RESET:    rst_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The borrow out of the subtract marks a timestamp before the press start,
  // which counts as zero elapsed time; then only a zero threshold is reached.
  assign diff         = {1'b0, beat_i.now} - {1'b0, start_q};
  assign before_start = diff[TW];
  assign ge_fb  = before_start ? (fb_thr_q == '0)
                               : (diff[TW-1:0] >= TW'(fb_thr_q));
  assign ge_sos = before_start ? (sos_thr_q == '0)
                               : (diff[TW-1:0] >= TW'(sos_thr_q));
  assign ge_rst = before_start ? (rst_thr_q == '0)
                               : (diff[TW-1:0] >= TW'(rst_thr_q));

  always_comb begin
    is_down_d     = is_down_q;
    start_d       = start_q;
    fb_d          = fb_q;
    sos_d         = sos_q;
    rflag_d       = rflag_q;
    res_o.event_res = bhc_pkg::EV_NONE;
    res_o.led       = bhc_pkg::LED_NONE;
    unique case (beat_i.func)
      bhc_pkg::FUNC_LEVEL: begin
        if (beat_i.pressed && !is_down_q) begin
          is_down_d = 1'b1;
          start_d   = beat_i.now;
          fb_d      = 1'b0;
          sos_d     = 1'b0;
          rflag_d   = 1'b0;
        end else if (!beat_i.pressed && is_down_q) begin
          is_down_d = 1'b0;
          fb_d      = 1'b0;
          priority if (rflag_q) begin
            res_o.event_res = bhc_pkg::EV_RESET_PATH;
            res_o.led       = bhc_pkg::LED_RESTORE;
            rflag_d         = 1'b0;
          end else if (sos_q) begin
            res_o.event_res = bhc_pkg::EV_SOS_ARM;
            res_o.led       = bhc_pkg::LED_SOS;
            sos_d           = 1'b0;
          end else if (ge_rst) begin
            res_o.event_res = bhc_pkg::EV_RESET_PATH;
            res_o.led       = bhc_pkg::LED_RESTORE;
          end else if (ge_sos) begin
            res_o.event_res = bhc_pkg::EV_SOS_ARM;
            res_o.led       = bhc_pkg::LED_SOS;
          end else if (fb_q) begin
            res_o.event_res = bhc_pkg::EV_HOLD_CANCEL;
            res_o.led       = bhc_pkg::LED_RESTORE;
          end else begin
            res_o.event_res = bhc_pkg::EV_ADVANCE;
          end
        end
      end
      bhc_pkg::FUNC_TICK: begin
        if (is_down_q) begin
          priority if (!fb_q && ge_fb) begin
            fb_d            = 1'b1;
            res_o.event_res = bhc_pkg::EV_HOLD_START;
            res_o.led       = bhc_pkg::LED_HOLD;
          end else if (!rflag_q && ge_rst) begin
            rflag_d         = 1'b1;
            res_o.event_res = bhc_pkg::EV_RESET_PATH;
            res_o.led       = bhc_pkg::LED_HOLD;
          end else if (!sos_q && !rflag_q && ge_sos) begin
            sos_d           = 1'b1;
            res_o.event_res = bhc_pkg::EV_SOS_ARM;
            res_o.led       = bhc_pkg::LED_SOS;
          end else begin
            res_o.event_res = bhc_pkg::EV_NONE;
          end
        end
      end
      bhc_pkg::FUNC_SOS: begin
        res_o.event_res = bhc_pkg::EV_SOS_DEDICATED;
        res_o.led       = bhc_pkg::LED_SOS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q <= 1'b0;
      start_q   <= '0;
      fb_q      <= 1'b0;
      sos_q     <= 1'b0;
      rflag_q   <= 1'b0;
    end else if (fire_i) begin
      is_down_q <= is_down_d;
      start_q   <= start_d;
      fb_q      <= fb_d;
      sos_q     <= sos_d;
      rflag_q   <= rflag_d;
    end
  end

endmodule

### design/bhc_out_stage.sv
// Result register: holds one result beat until the consumer takes it.
module bhc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bhc_pkg::res_beat_t  res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bhc_pkg::res_beat_t  res_o
);

  logic               valid_q, valid_d;
  bhc_pkg::res_beat_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/button_hold_classifier.sv
// Top level of the button hold classifier: input register, core, result register.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------
//   in       | in        | in_valid_i / in_stall_o | func_i, pressed_i, now_ms_i
//   out      | out       | out_valid_o / out_stall_i | event_res_o, led_o
//   cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One beat in per cycle is sustained while the result side does not stall;
// each result passes through the input register and then the result register
// around the combinational subtract and threshold compares.
// Reset clears the press state and loads the default thresholds at once.
// A stall on the result side holds the result register; the input register
// still takes a beat if empty, then in_stall_o rises until the result drains.
module button_hold_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic        pressed_i,
  input  logic [63:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [1:0]  led_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  bhc_pkg::in_beat_t  beat_in, beat_q;
  bhc_pkg::res_beat_t res_comb, res_q;
  logic               stage_valid;
  logic               out_free;
  logic               fire;

  assign beat_in.func    = func_i;
  assign beat_in.pressed = pressed_i;
  assign beat_in.now     = now_ms_i[bhc_pkg::TimeWidth-1:0];

  assign fire = stage_valid && out_free;

  bhc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (beat_in),
    .take_i     (fire),
    .valid_o    (stage_valid),
    .beat_o     (beat_q)
  );

  bhc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .beat_i     (beat_q),
    .res_o      (res_comb)
  );

  bhc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_comb),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign event_res_o = res_q.event_res;
  assign led_o       = res_q.led;

`ifndef ASSERT_OFF
  // The input side only stalls while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A beat taken while the result is blocked waits in the input register.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_valid_i && !in_stall_o) |=>
      (stage_valid && out_valid_o))
    else $error("input register accepted past a blocked result");

  a_ded_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == bhc_pkg::EV_SOS_DEDICATED) |-> led_o == bhc_pkg::LED_SOS)
    else $error("dedicated SOS result without SOS pattern");

  a_hold_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == bhc_pkg::EV_HOLD_START) |-> led_o == bhc_pkg::LED_HOLD)
    else $error("hold start result without hold pattern");
`endif

endmodule

### verif/button_hold_classifier_tb.sv
// Self-checking testbench for the button hold classifier with its own press-state predictor.
module button_hold_classifier_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic        pressed;
    logic [63:0] stamp;
    logic        typed;
    logic [2:0]  event_res;
    logic [1:0]  led;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = bhc_pkg::FUNC_LEVEL;
  logic        pressed_i = 1'b0;
  logic [63:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [1:0]  led_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = bhc_pkg::REG_FEEDBACK;
  logic [15:0] cfg_data_i = '0;

  // Predictor copy of the press state and the thresholds.
  logic                          btn_down = 1'b0;
  logic [bhc_pkg::TimeWidth-1:0] btn_start = '0;
  logic                          fb_done = 1'b0;
  logic                          sos_set = 1'b0;
  logic                          rst_armed = 1'b0;
  logic [bhc_pkg::ThrWidth-1:0]  thr_feedback = bhc_pkg::FEEDBACK_RST;
  logic [bhc_pkg::ThrWidth-1:0]  thr_sos = bhc_pkg::SOS_HOLD_RST;
  logic [bhc_pkg::ThrWidth-1:0]  thr_reset = bhc_pkg::RESET_RST;

  bhc_pkg::res_beat_t expected_res [$];
  bhc_pkg::res_beat_t want_res;
  int unsigned        mismatch_cnt = 0;
  logic [63:0]        clock_ms = '0;
  bit                 idle_on = 1'b1;
  bit                 valid_up = 1'b0;
  bit                 long_hold = 1'b0;

  dir_row_t dir_rows [26] = '{
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd100,  1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd0,    1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_SOS,   1'b0, 64'd0,    1'b1, bhc_pkg::EV_SOS_DEDICATED, bhc_pkg::LED_SOS},
    '{FUNC_UNUSED,         1'b1, '1,       1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd1000, 1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd1200, 1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd1499, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b1, 64'd1500, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd1600, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd3000, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd6000, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_SOS,   1'b1, 64'd6050, 1'b1, bhc_pkg::EV_SOS_DEDICATED, bhc_pkg::LED_SOS},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd6100, 1'b1, bhc_pkg::EV_RESET_PATH, bhc_pkg::LED_RESTORE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, '1,       1'b1, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd0,    1'b1, bhc_pkg::EV_ADVANCE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd10,   1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd600,  1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd700,  1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd20,   1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd2520, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd0,    1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b0, 64'd5000, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_LEVEL, 1'b1, 64'd100,  1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd6000, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd6001, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE},
    '{bhc_pkg::FUNC_TICK,  1'b0, 64'd6002, 1'b0, bhc_pkg::EV_NONE, bhc_pkg::LED_NONE}
  };

  button_hold_classifier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .pressed_i   (pressed_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .led_o       (led_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Updates the press state for one beat and returns the event and LED it causes.
  function automatic bhc_pkg::res_beat_t classify_beat(logic [1:0] f, logic p,
                                                       logic [63:0] stamp);
    bhc_pkg::res_beat_t            r;
    logic [bhc_pkg::TimeWidth-1:0] t;
    logic [bhc_pkg::TimeWidth-1:0] held;
    r.event_res = bhc_pkg::EV_NONE;
    r.led       = bhc_pkg::LED_NONE;
    t           = stamp[bhc_pkg::TimeWidth-1:0];
    // A timestamp earlier than the press start counts as no hold time at all.
    held        = (t >= btn_start) ? t - btn_start : '0;
    case (f)
      bhc_pkg::FUNC_LEVEL: begin
        if (p && !btn_down) begin
          btn_down  = 1'b1;
          btn_start = t;
          fb_done   = 1'b0;
          sos_set   = 1'b0;
          rst_armed = 1'b0;
        end else if (!p && btn_down) begin
          btn_down = 1'b0;
          if (rst_armed) begin
            r.event_res = bhc_pkg::EV_RESET_PATH;
            r.led       = bhc_pkg::LED_RESTORE;
            rst_armed   = 1'b0;
          end else if (sos_set) begin
            r.event_res = bhc_pkg::EV_SOS_ARM;
            r.led       = bhc_pkg::LED_SOS;
            sos_set     = 1'b0;
          end else if (held >= thr_reset) begin
            r.event_res = bhc_pkg::EV_RESET_PATH;
            r.led       = bhc_pkg::LED_RESTORE;
          end else if (held >= thr_sos) begin
            r.event_res = bhc_pkg::EV_SOS_ARM;
            r.led       = bhc_pkg::LED_SOS;
          end else if (fb_done) begin
            r.event_res = bhc_pkg::EV_HOLD_CANCEL;
            r.led       = bhc_pkg::LED_RESTORE;
          end else begin
            r.event_res = bhc_pkg::EV_ADVANCE;
          end
          fb_done = 1'b0;
        end
      end
      bhc_pkg::FUNC_TICK: begin
        if (btn_down) begin
          if (!fb_done && held >= thr_feedback) begin
            fb_done     = 1'b1;
            r.event_res = bhc_pkg::EV_HOLD_START;
            r.led       = bhc_pkg::LED_HOLD;
          end else if (!rst_armed && held >= thr_reset) begin
            rst_armed   = 1'b1;
            r.event_res = bhc_pkg::EV_RESET_PATH;
            r.led       = bhc_pkg::LED_HOLD;
          end else if (!sos_set && !rst_armed && held >= thr_sos) begin
            sos_set     = 1'b1;
            r.event_res = bhc_pkg::EV_SOS_ARM;
            r.led       = bhc_pkg::LED_SOS;
          end
        end
      end
      bhc_pkg::FUNC_SOS: begin
        r.event_res = bhc_pkg::EV_SOS_DEDICATED;
        r.led       = bhc_pkg::LED_SOS;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Offers one beat, holds it until accepted, then records what it should produce.
  task automatic push_beat(input logic [1:0] f, input logic p, input logic [63:0] stamp,
                           input bit typed = 1'b0,
                           input bhc_pkg::res_beat_t typed_res = '0);
    bhc_pkg::res_beat_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      if (valid_up) in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    valid_up   = 1'b1;
    func_i     <= f;
    pressed_i  <= p;
    now_ms_i   <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = classify_beat(f, p, stamp);
    expected_res.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    if (valid_up) in_valid_i <= 1'b0;
    valid_up = 1'b0;
    @(posedge clk_i);
    while (expected_res.size() != 0) @(posedge clk_i);
  endtask

  // Writes all three thresholds on consecutive cycles; only called with nothing in flight.
  task automatic apply_config(input logic [15:0] fb, input logic [15:0] sos,
                              input logic [15:0] rst);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bhc_pkg::REG_FEEDBACK;
    cfg_data_i <= fb;
    @(posedge clk_i);
    cfg_idx_i  <= bhc_pkg::REG_SOS_HOLD;
    cfg_data_i <= sos;
    @(posedge clk_i);
    cfg_idx_i  <= bhc_pkg::REG_RESET;
    cfg_data_i <= rst;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_feedback = fb;
    thr_sos      = sos;
    thr_reset    = rst;
  endtask

  // Mostly complete presses with random tick spacing, some raw noise beats in between.
  task automatic run_random(input int unsigned n_items);
    int unsigned done_cnt;
    int unsigned span;
    int unsigned n_ticks;
    logic [63:0] stamp;
    logic [1:0]  f;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      span = 32'(thr_feedback);
      if (32'(thr_sos) > span) span = 32'(thr_sos);
      if (32'(thr_reset) > span) span = 32'(thr_reset);
      span = span / 3 + 16;
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 15))
          0:       clock_ms = {$urandom, $urandom};
          1:       clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2 * span);
          default: clock_ms = clock_ms + $urandom_range(0, span);
        endcase
        push_beat(bhc_pkg::FUNC_LEVEL, 1'b1, clock_ms);
        done_cnt++;
        n_ticks = $urandom_range(0, 10);
        repeat (n_ticks) begin
          if ($urandom_range(0, 15) == 0) begin
            stamp = clock_ms - $urandom_range(1, span);
          end else begin
            clock_ms = clock_ms + $urandom_range(0, span);
            stamp    = clock_ms;
          end
          case ($urandom_range(0, 11))
            0:       f = bhc_pkg::FUNC_SOS;
            1:       f = bhc_pkg::FUNC_LEVEL;
            2:       f = FUNC_UNUSED;
            default: f = bhc_pkg::FUNC_TICK;
          endcase
          // A level beat inside a press repeats the pressed level, so it is not an edge.
          push_beat(f, (f == bhc_pkg::FUNC_LEVEL) ? 1'b1 : 1'($urandom_range(0, 1)), stamp);
          done_cnt++;
        end
        if ($urandom_range(0, 9) == 0) begin
          stamp = clock_ms - $urandom_range(1, 2 * span);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, span);
          stamp    = clock_ms;
        end
        push_beat(bhc_pkg::FUNC_LEVEL, 1'b0, stamp);
        done_cnt++;
      end else begin
        f = 2'($urandom_range(0, 3));
        push_beat(f, 1'($urandom_range(0, 1)), {$urandom, $urandom});
        done_cnt++;
      end
    end
  endtask

  // Result-side stall: short random bursts, or one long hold-off when the sender asks.
  initial begin
    int unsigned n;
    forever begin
      n = 0;
      if (long_hold) n = 40;
      else if (idle_on && $urandom_range(0, 5) == 0) n = $urandom_range(1, 3);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        long_hold = 1'b0;
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending: event %0d led %0d",
                                  event_res_o, led_o));
      end else begin
        want_res = expected_res.pop_front();
        if (event_res_o !== want_res.event_res)
          report_mismatch($sformatf("event_res %0d, predicted %0d",
                                    event_res_o, want_res.event_res));
        if (led_o !== want_res.led)
          report_mismatch($sformatf("led %0d, predicted %0d", led_o, want_res.led));
      end
    end
  end

  initial begin
    #800000;
    $display("TIMEOUT at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bhc_pkg::res_beat_t typed_res;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_res.event_res = dir_rows[i].event_res;
      typed_res.led       = dir_rows[i].led;
      push_beat(dir_rows[i].func, dir_rows[i].pressed, dir_rows[i].stamp,
                dir_rows[i].typed, typed_res);
    end
    drain_results();

    // Zero thresholds are reached on the first tick of every press.
    apply_config(16'd0, 16'd0, 16'd0);
    run_random(220);
    drain_results();

    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(220);
    drain_results();

    // Hold the result side long enough for the input side to back up.
    apply_config(bhc_pkg::FEEDBACK_RST, bhc_pkg::SOS_HOLD_RST, bhc_pkg::RESET_RST);
    long_hold = 1'b1;
    run_random(12);
    drain_results();
    run_random(220);
    drain_results();

    apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    run_random(220);
    drain_results();

    // Reset threshold below the SOS one, so the SOS arm never gets its turn on a tick.
    apply_config(16'd100, 16'd3000, 16'd1000);
    run_random(220);
    drain_results();

    idle_on = 1'b0;
    apply_config(16'd800, 16'd300, 16'd1200);
    run_random(220);
    drain_results();

    repeat (6) @(posedge clk_i);
    if (expected_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_res.size()));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/bhc_pkg.sv
design/bhc_in_stage.sv
design/bhc_core.sv
design/bhc_out_stage.sv
design/button_hold_classifier.sv
verif/button_hold_classifier_tb.sv
